### sv/pgch_pkg.sv
// Shared types and constants for the particle grid cell histogram.
package pgch_pkg;

  localparam int PGCH_MAX_CELLS   = 4096;
  localparam int PGCH_COUNT_WIDTH = 16;
  localparam int PGCH_IDX_W       = 12;
  localparam int PGCH_CNT_W       = 16;
  localparam int PGCH_N_W         = 13;
  localparam int PGCH_CFG_IDX_W   = 3;

  localparam logic [31:0]         PGCH_INV_RESET = 32'd65536;
  localparam logic [PGCH_N_W-1:0] PGCH_N_RESET   = 13'd16;

  typedef enum logic [PGCH_CFG_IDX_W-1:0] {
    REG_MIN_X    = 3'd0,
    REG_MIN_Y    = 3'd1,
    REG_MIN_Z    = 3'd2,
    REG_INV_CELL = 3'd3,
    REG_NX       = 3'd4,
    REG_NY       = 3'd5,
    REG_NZ       = 3'd6
  } pgch_reg_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic [31:0]        inv_cell;
    logic [PGCH_N_W-1:0] nx;
    logic [PGCH_N_W-1:0] ny;
    logic [PGCH_N_W-1:0] nz;
  } pgch_cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pgch_in_t;

  typedef struct packed {
    logic [PGCH_IDX_W-1:0] cell_index;
    logic [PGCH_CNT_W-1:0] cell_count;
    logic                  out_of_range;
  } pgch_out_t;

endpackage

### sv/pgch_index.sv
// Five-stage pipeline from particle position to linear cell index and range flag.
module pgch_index import pgch_pkg::*; #(
  parameter int MAX_CELLS = PGCH_MAX_CELLS,
  localparam int AW = $clog2(MAX_CELLS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pgch_cfg_t     cfg,
  input  logic          s_valid,
  output logic          s_ready,
  input  pgch_in_t      s_data,
  output logic          a_valid,
  output logic          a_ok,
  output logic [AW-1:0] a_idx,
  input  logic          a_ready
);

  localparam logic [39:0] DEPTH = 40'(MAX_CELLS);

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [32:0] s1_d_r   [3];
  logic [32:0] s1_d_nxt [3];
  logic        s2_bad_r   [3];
  logic        s2_bad_nxt [3];
  logic [31:0] s2_c_r   [3];
  logic [31:0] s2_c_nxt [3];
  logic        s3_ok_r, s3_ok_nxt;
  logic [12:0] s3_c_r [3];
  logic        s4_ok_r;
  logic [12:0] s4_cx_r;
  logic [25:0] s4_py_r, s4_py_nxt;
  logic [38:0] s4_pz_r, s4_pz_nxt;
  logic        s5_ok_r, s5_ok_nxt;
  logic [AW-1:0] s5_idx_r;
  logic [39:0] sum;
  logic [25:0] nxny_r;

  logic [31:0]         pos  [3];
  logic [31:0]         lo   [3];
  logic [PGCH_N_W-1:0] n    [3];
  logic [63:0]         prod [3];
  logic                axis_ok [3];

  assign pos[0] = s_data.pos_x;
  assign pos[1] = s_data.pos_y;
  assign pos[2] = s_data.pos_z;
  assign lo[0]  = cfg.min_x;
  assign lo[1]  = cfg.min_y;
  assign lo[2]  = cfg.min_z;
  assign n[0]   = cfg.nx;
  assign n[1]   = cfg.ny;
  assign n[2]   = cfg.nz;

  // Backpressure: a stage loads when empty or when its successor moves.
  assign rdy5    = !s5_v_r || a_ready;
  assign rdy4    = !s4_v_r || rdy5;
  assign rdy3    = !s3_v_r || rdy4;
  assign rdy2    = !s2_v_r || rdy3;
  assign rdy1    = !s1_v_r || rdy2;
  assign s_ready = rdy1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_d_nxt[i] = {pos[i][31], pos[i]} - {lo[i][31], lo[i]};
      // With a zero reciprocal the product is zero, which covers that case.
      prod[i]       = 64'(s1_d_r[i][31:0]) * 64'(cfg.inv_cell);
      s2_c_nxt[i]   = prod[i][63:32];
      s2_bad_nxt[i] = s1_d_r[i][32] && (cfg.inv_cell != 32'd0);
      axis_ok[i]    = !s2_bad_r[i] && (s2_c_r[i] < {19'd0, n[i]});
    end
    s3_ok_nxt = axis_ok[0] && axis_ok[1] && axis_ok[2];
    s4_py_nxt = {13'd0, s3_c_r[1]} * {13'd0, cfg.nx};
    s4_pz_nxt = {26'd0, s3_c_r[2]} * {13'd0, nxny_r};
    sum       = 40'(s4_cx_r) + 40'(s4_py_r) + 40'(s4_pz_r);
    s5_ok_nxt = s4_ok_r && (sum < DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= s_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      if (rdy5) s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    nxny_r <= {13'd0, cfg.nx} * {13'd0, cfg.ny};
    if (rdy1) s1_d_r <= s1_d_nxt;
    if (rdy2) begin
      s2_c_r   <= s2_c_nxt;
      s2_bad_r <= s2_bad_nxt;
    end
    if (rdy3) begin
      s3_ok_r <= s3_ok_nxt;
      for (int i = 0; i < 3; i++) begin
        s3_c_r[i] <= s2_c_r[i][12:0];
      end
    end
    if (rdy4) begin
      s4_ok_r <= s3_ok_r;
      s4_cx_r <= s3_c_r[0];
      s4_py_r <= s4_py_nxt;
      s4_pz_r <= s4_pz_nxt;
    end
    if (rdy5) begin
      s5_ok_r  <= s5_ok_nxt;
      s5_idx_r <= sum[AW-1:0];
    end
  end

  assign a_valid = s5_v_r;
  assign a_ok    = s5_ok_r;
  assign a_idx   = s5_idx_r;

endmodule

### sv/pgch_store.sv
// Count memory with read-modify-write, write forwarding, clear sweep and output register.
module pgch_store import pgch_pkg::*; #(
  parameter int MAX_CELLS   = PGCH_MAX_CELLS,
  parameter int COUNT_WIDTH = PGCH_COUNT_WIDTH,
  localparam int AW = $clog2(MAX_CELLS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          a_valid,
  input  logic          a_ok,
  input  logic [AW-1:0] a_idx,
  output logic          a_ready,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output pgch_out_t     out_data
);

  localparam logic [AW-1:0] LAST = AW'(MAX_CELLS - 1);

  logic [COUNT_WIDTH-1:0] mem [MAX_CELLS];
  logic [COUNT_WIDTH-1:0] rd_data_r;

  logic                   clr_busy_r;
  logic [AW-1:0]          clr_addr_r;

  logic                   b_valid_r;
  logic                   b_ok_r;
  logic [AW-1:0]          b_idx_r;
  logic                   b_fwd_r;
  logic [COUNT_WIDTH-1:0] b_fwd_data_r;

  logic                   out_valid_r;
  pgch_out_t              out_data_r;

  logic                   out_ready;
  logic                   b_move;
  logic                   rd_en;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_new;

  assign out_ready = !out_valid_r || !out_stall;
  assign b_move    = b_valid_r && out_ready;
  assign a_ready   = !clr_busy_r && (!b_valid_r || out_ready);
  assign rd_en     = a_valid && a_ready && a_ok;
  assign busy      = clr_busy_r;

  // Take the value written in the cycle of our read, else the memory output.
  assign cnt_cur = b_fwd_r ? b_fwd_data_r : rd_data_r;
  assign cnt_new = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

  assign wr_en   = clr_busy_r || (b_move && b_ok_r);
  assign wr_addr = clr_busy_r ? clr_addr_r : b_idx_r;
  assign wr_data = clr_busy_r ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[a_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST) clr_busy_r <= 1'b0;
      end
      if (a_ready) b_valid_r <= a_valid;
      if (b_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      b_ok_r       <= a_ok;
      b_idx_r      <= a_idx;
      b_fwd_r      <= wr_en && (wr_addr == a_idx);
      b_fwd_data_r <= wr_data;
    end
    if (b_move) begin
      if (b_ok_r) begin
        out_data_r.cell_index   <= PGCH_IDX_W'(b_idx_r);
        out_data_r.cell_count   <= PGCH_CNT_W'(cnt_new);
        out_data_r.out_of_range <= 1'b0;
      end else begin
        out_data_r.cell_index   <= '0;
        out_data_r.cell_count   <= '0;
        out_data_r.out_of_range <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_clear_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!a_ready && !b_valid_r))
    else $error("item admitted during clear sweep");

  a_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_ready) |=> (b_valid_r && $stable(b_idx_r) && $stable(b_ok_r)))
    else $error("RMW stage lost its item while output blocked");

  a_commit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (b_move && b_ok_r) |=> (out_valid_r && !out_data_r.out_of_range))
    else $error("counted item reported out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("output register changed under stall");

endmodule

### sv/particle_grid_cell_histogram.sv
// Top level: configuration registers, index pipeline and count store.
//
// Usage: each input transfer carries one particle position (pos_x, pos_y,
// pos_z, signed Q16.16). The block bins it into a uniform grid set by the
// min_x/y/z, inv_cell and nx/ny/nz registers, bumps that cell's saturating
// count and returns one result: cell index, new count and out_of_range.
// Particles outside the grid or beyond MAX_CELLS return index 0, count 0
// and out_of_range set, and leave the counts untouched.
// Structure: five index stages, one read-modify-write stage and an output
// register. Throughput is one particle per cycle while out_stall is low and
// no clear sweep runs; the count memory takes one read and one write a
// cycle, and back-to-back hits on one cell forward the written count.
// Reset: registers return to their defaults and a clear sweep zeroes the
// count memory, one entry a cycle, with in_stall held high; configuration
// writes are taken throughout (cfg_ready is always 1).
// Write configuration only with no particle in flight.
// When out_stall is high the result holds and the pipeline fills, then
// in_stall rises until the output drains.
module particle_grid_cell_histogram import pgch_pkg::*; #(
  parameter int MAX_CELLS   = PGCH_MAX_CELLS,
  parameter int COUNT_WIDTH = PGCH_COUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pgch_in_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pgch_out_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [PGCH_CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);

  pgch_cfg_t     cfg_r;
  logic          s_ready;
  logic          busy;
  logic          a_valid;
  logic          a_ok;
  logic [AW-1:0] a_idx;
  logic          a_ready;

  assign cfg_ready = 1'b1;
  assign in_stall  = !s_ready || busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_x    <= '0;
      cfg_r.min_y    <= '0;
      cfg_r.min_z    <= '0;
      cfg_r.inv_cell <= PGCH_INV_RESET;
      cfg_r.nx       <= PGCH_N_RESET;
      cfg_r.ny       <= PGCH_N_RESET;
      cfg_r.nz       <= PGCH_N_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pgch_reg_t'(cfg_index))
        REG_MIN_X:    cfg_r.min_x    <= cfg_data;
        REG_MIN_Y:    cfg_r.min_y    <= cfg_data;
        REG_MIN_Z:    cfg_r.min_z    <= cfg_data;
        REG_INV_CELL: cfg_r.inv_cell <= cfg_data;
        REG_NX:       cfg_r.nx       <= cfg_data[PGCH_N_W-1:0];
        REG_NY:       cfg_r.ny       <= cfg_data[PGCH_N_W-1:0];
        REG_NZ:       cfg_r.nz       <= cfg_data[PGCH_N_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  pgch_index #(
    .MAX_CELLS (MAX_CELLS)
  ) u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .s_valid (in_valid && !busy),
    .s_ready (s_ready),
    .s_data  (in_data),
    .a_valid (a_valid),
    .a_ok    (a_ok),
    .a_idx   (a_idx),
    .a_ready (a_ready)
  );

  pgch_store #(
    .MAX_CELLS   (MAX_CELLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid),
    .a_ok      (a_ok),
    .a_idx     (a_idx),
    .a_ready   (a_ready),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/tb.sv
// Testbench for the particle grid cell histogram: directed, same-cell and random binning checks.
`timescale 1ns / 1ps

module tb import pgch_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [PGCH_CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  pgch_in_t                  in_data;
  logic                      out_valid;
  logic                      out_stall;
  pgch_out_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [PGCH_CFG_IDX_W-1:0] cfg_index;
  logic [31:0]               cfg_data;

  // Shadow grid setup and count store.
  logic signed [31:0]  grid_min_x, grid_min_y, grid_min_z;
  logic [31:0]         grid_inv;
  logic [PGCH_N_W-1:0] grid_nx, grid_ny, grid_nz;
  logic [PGCH_CNT_W-1:0] cell_tally [PGCH_MAX_CELLS];

  pgch_out_t pending_bins[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        idle_in_pct = 0;
  int        stall_pct = 0;

  particle_grid_cell_histogram i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL particle_grid_cell_histogram");
      $finish;
    end
  end

  // Cell coordinate on one axis in c; returns 0 when it falls outside [0, n).
  function automatic logic axis_cell(input logic signed [31:0] p, input logic signed [31:0] lo,
                                     input logic [PGCH_N_W-1:0] n,
                                     output longint unsigned c);
    logic [32:0] d;
    c = 0;
    d = {p[31], p} - {lo[31], lo};
    if (d[32]) begin
      if (grid_inv != 0) return 1'b0;
    end else begin
      c = ({32'b0, d[31:0]} * {32'b0, grid_inv}) >> 32;
    end
    return c < longint'(n);
  endfunction

  function automatic pgch_out_t bin_particle(input pgch_in_t p);
    longint unsigned cx, cy, cz, idx;
    logic            ok;
    pgch_out_t       r;
    r = '0;
    idx = 0;
    ok = axis_cell(p.pos_x, grid_min_x, grid_nx, cx);
    if (ok) ok = axis_cell(p.pos_y, grid_min_y, grid_ny, cy);
    if (ok) ok = axis_cell(p.pos_z, grid_min_z, grid_nz, cz);
    if (ok) begin
      idx = cx + cy * 64'(grid_nx) + cz * 64'(grid_nx) * 64'(grid_ny);
      if (idx >= PGCH_MAX_CELLS) ok = 1'b0;
    end
    if (!ok) begin
      r.out_of_range = 1'b1;
      return r;
    end
    if (cell_tally[idx] != '1) cell_tally[idx]++;
    r.cell_index = idx[PGCH_IDX_W-1:0];
    r.cell_count = cell_tally[idx];
    return r;
  endfunction

  // Predict on input transfers, check on output transfers.
  always @(posedge clk) begin
    pgch_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_bins.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: idx %0d count %0d oor %0b",
                     out_data.cell_index, out_data.cell_count, out_data.out_of_range);
        end else begin
          want = pending_bins.pop_front();
          if (out_data.cell_index !== want.cell_index ||
              out_data.cell_count !== want.cell_count ||
              out_data.out_of_range !== want.out_of_range) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected idx %0d count %0d oor %0b, got %0d %0d %0b",
                       want.cell_index, want.cell_count, want.out_of_range,
                       out_data.cell_index, out_data.cell_count, out_data.out_of_range);
          end
        end
      end
      if (in_valid && !in_stall) pending_bins.push_back(bin_particle(in_data));
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic pgch_in_t particle(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
    pgch_in_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    return p;
  endfunction

  task automatic send_particle(input pgch_in_t p);
    @(negedge clk);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      in_data  <= particle($urandom, $urandom, $urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid after the last transfer and wait for every result.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PGCH_CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_X:    grid_min_x = value;
      REG_MIN_Y:    grid_min_y = value;
      REG_MIN_Z:    grid_min_z = value;
      REG_INV_CELL: grid_inv   = value;
      REG_NX:       grid_nx    = value[PGCH_N_W-1:0];
      REG_NY:       grid_ny    = value[PGCH_N_W-1:0];
      REG_NZ:       grid_nz    = value[PGCH_N_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_grid(input logic [31:0] mx, input logic [31:0] my, input logic [31:0] mz,
                            input logic [31:0] inv, input logic [31:0] nx,
                            input logic [31:0] ny, input logic [31:0] nz);
    write_reg(REG_MIN_X, mx);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_MIN_Z, mz);
    write_reg(REG_INV_CELL, inv);
    write_reg(REG_NX, nx);
    write_reg(REG_NY, ny);
    write_reg(REG_NZ, nz);
  endtask

  task automatic test_reset_defaults();
    idle_in_pct = 0;
    stall_pct = 0;
    send_particle(particle(32'h0, 32'h0, 32'h0));
    send_particle(particle(32'h0, 32'h0, 32'h0));
    send_particle(particle(32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF));
    send_particle(particle(32'h0010_0000, 32'h0, 32'h0));
    send_particle(particle(32'hFFFF_FFFF, 32'h0, 32'h0));
    send_particle(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    drain_results();
  endtask

  task automatic test_register_extremes();
    // Widest span: most negative bound, tiny reciprocal.
    write_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 16, 16, 16);
    send_particle(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    drain_results();
    // Largest reciprocal.
    write_grid(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 16, 16, 16);
    send_particle(particle(32'h1, 32'h0, 32'h0));
    send_particle(particle(32'h2, 32'h0, 32'h0));
    drain_results();
    // Zero reciprocal folds everything, below the bound too, onto cell zero.
    write_reg(REG_INV_CELL, 32'h0);
    write_reg(REG_MIN_X, 32'h7FFF_FFFF);
    send_particle(particle(32'h8000_0000, 32'hFFFF_0000, 32'h1234_5678));
    drain_results();
    // Zero size flags every particle; upper data bits are dropped.
    write_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_E000, 16, 16);
    send_particle(particle(32'h0, 32'h0, 32'h0));
    drain_results();
    // Widest axis, index past the store depth.
    write_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h1FFF, 1, 1);
    send_particle(particle(32'h0FFF_8000, 32'h0, 32'h0));
    send_particle(particle(32'h1000_0000, 32'h0, 32'h0));
    drain_results();
    // Write to an undefined index: no effect.
    write_reg(REG_UNUSED, 32'h0000_0001);
    send_particle(particle(32'h0FFF_0000, 32'h0000_8000, 32'h0000_8000));
    drain_results();
  endtask

  // Back-to-back hits on one cell exercise the count forwarding.
  task automatic test_same_cell_burst();
    idle_in_pct = 0;
    stall_pct = 0;
    write_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 16, 16, 16);
    for (int i = 0; i < 20; i++)
      send_particle(particle(32'h0003_8000, 32'h0002_8000, 32'h0001_8000));
    drain_results();
  endtask

  function automatic logic [31:0] aim_axis(input logic signed [31:0] lo,
                                           input logic [PGCH_N_W-1:0] n);
    longint unsigned span, off;
    longint          p;
    if (grid_inv == 0) span = 64'h1_0000_0000;
    else span = (64'(n) << 32) / 64'(grid_inv);
    if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
    off = {$urandom, $urandom} % (span + (span >> 3) + 1);
    p = longint'(lo) + longint'(off) - longint'(span >> 4);
    if (p > 64'sd2147483647 || p < -64'sd2147483648 || $urandom_range(15) == 0)
      return $urandom;
    return p[31:0];
  endfunction

  task automatic randomize_grid();
    logic [31:0] mins [3];
    logic [31:0] dims [3];
    logic [31:0] inv;
    int          sel;
    for (int a = 0; a < 3; a++) begin
      mins[a] = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      dims[a] = ($urandom_range(7) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 24);
      dims[a] = dims[a] | ($urandom & 32'hFFFF_E000);
    end
    sel = $urandom_range(9);
    if (sel < 4) inv = 32'h0001_0000;
    else if (sel < 8) inv = $urandom_range(1, 32'h0008_0000);
    else if (sel < 9) inv = $urandom;
    else inv = 32'h0;
    write_grid(mins[0], mins[1], mins[2], inv, dims[0], dims[1], dims[2]);
  endtask

  task automatic test_random_traffic();
    int idle_modes [4] = '{0, 69, 0, 9};
    int stall_modes [4] = '{0, 0, 69, 9};
    for (int m = 0; m < 4; m++) begin
      for (int g = 0; g < 2; g++) begin
        randomize_grid();
        idle_in_pct = idle_modes[m];
        stall_pct = stall_modes[m];
        for (int i = 0; i < 244; i++) begin
          if ($urandom_range(9) == 0)
            send_particle(particle($urandom, $urandom, $urandom));
          else
            send_particle(particle(aim_axis(grid_min_x, grid_nx), aim_axis(grid_min_y, grid_ny),
                                   aim_axis(grid_min_z, grid_nz)));
        end
        drain_results();
        stall_pct = 0;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_X;
    cfg_data = '0;
    grid_min_x = '0;
    grid_min_y = '0;
    grid_min_z = '0;
    grid_inv = PGCH_INV_RESET;
    grid_nx = PGCH_N_RESET;
    grid_ny = PGCH_N_RESET;
    grid_nz = PGCH_N_RESET;
    for (int i = 0; i < PGCH_MAX_CELLS; i++) cell_tally[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_same_cell_burst();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bins.size() == 0) begin
      $display("PASS particle_grid_cell_histogram");
    end else begin
      $display("FAIL particle_grid_cell_histogram");
    end
    $finish;
  end

endmodule
